[design/quoted_bracket_balance_checker_assert.svh]
// Assertion macros shared by the bracket checker RTL.
`ifndef QUOTED_BRACKET_BALANCE_CHECKER_ASSERT_SVH
`define QUOTED_BRACKET_BALANCE_CHECKER_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define QBBC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define QBBC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/qbbc_pkg.sv]
// Package: constants, codes and types for the quoted bracket checker.
package qbbc_pkg;

   localparam int MAX_DEPTH = 64;
   localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);

   localparam logic [7:0] CH_QUOTE   = 8'h27;
   localparam logic [7:0] CH_LROUND  = 8'h28;
   localparam logic [7:0] CH_RROUND  = 8'h29;
   localparam logic [7:0] CH_LSQUARE = 8'h5B;
   localparam logic [7:0] CH_RSQUARE = 8'h5D;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;

   localparam logic KIND_ROUND  = 1'b0;
   localparam logic KIND_SQUARE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_MISMATCH = 2'd1,
      ST_UNCLOSED = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic kind;
   } stack_ctl_type;

endpackage

[design/quoted_bracket_balance_checker.sv]
// Top level: quoted bracket balance checker with stream in and out channels.
//
// Input beats carry one message byte in req_tdata[7:0]; req_tlast marks the
// final byte. Round and square brackets must nest and match; inside single
// quotes brackets are ignored and a backslash skips the next byte. The first
// error (mismatched closer, closer on empty stack, overflow past 64 open
// brackets) is latched and later bytes are ignored until the message ends.
// One result beat follows each final byte: rsp_tdata[0] well_formed,
// rsp_tdata[2:1] status (0 ok, 1 mismatch, 2 unclosed, 3 overflow).
// Throughput is one byte per cycle while req_tready is high: each byte does
// at most one push or pop on a row of shifting cells, resolved in the cycle
// it is accepted. The result of the final byte is registered into the buffer.
// Results wait in a two-entry output buffer; req_tready drops only while
// both entries are full, so a stalled receiver holds back input only then.
// Synchronous reset clears the depth count, quote and error state and the
// output buffer; no clearing pass is needed, the stack cells are read only
// below the depth count.
module quoted_bracket_balance_checker
   import qbbc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] well_formed, [2:1] status, [7:3] zero
);

   `include "quoted_bracket_balance_checker_assert.svh"

   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               quote_ff, quote_in;
   logic               esc_ff, esc_in;
   status_type         err_ff, err_in;

   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_data_ff, out_data_in;
   logic               skid_valid_ff, skid_valid_in;
   logic [7:0]         skid_data_ff, skid_data_in;

   stack_ctl_type      ctl;
   logic               top_kind;
   logic               accept;
   logic               emit;
   logic [DEPTH_W-1:0] step_depth;
   logic               step_quote;
   logic               step_esc;
   status_type         step_err;
   status_type         status;
   logic [7:0]         result;

   assign accept = req_tvalid && req_tready;
   assign emit   = accept && req_tlast;

   qbbc_stack u_stack (
      .clock    (clock),
      .ctl      (ctl),
      .top_kind (top_kind)
   );

   always_comb begin
      ctl        = '0;
      step_depth = depth_ff;
      step_quote = quote_ff;
      step_esc   = esc_ff;
      step_err   = err_ff;
      if (accept && err_ff == ST_OK) begin
         if (quote_ff) begin
            if (esc_ff) begin
               step_esc = 1'b0;
            end else if (req_tdata == CH_BSLASH) begin
               step_esc = 1'b1;
            end else if (req_tdata == CH_QUOTE) begin
               step_quote = 1'b0;
            end
         end else begin
            case (req_tdata)
               CH_QUOTE: begin
                  step_quote = 1'b1;
               end
               CH_LROUND, CH_LSQUARE: begin
                  if (depth_ff == DEPTH_W'(MAX_DEPTH)) begin
                     step_err = ST_OVERFLOW;
                  end else begin
                     ctl.push   = 1'b1;
                     ctl.kind   = (req_tdata == CH_LSQUARE) ? KIND_SQUARE : KIND_ROUND;
                     step_depth = depth_ff + DEPTH_W'(1);
                  end
               end
               CH_RROUND, CH_RSQUARE: begin
                  if (depth_ff == '0 ||
                      top_kind != ((req_tdata == CH_RSQUARE) ? KIND_SQUARE : KIND_ROUND)) begin
                     step_err = ST_MISMATCH;
                  end else begin
                     ctl.pop    = 1'b1;
                     step_depth = depth_ff - DEPTH_W'(1);
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      if (step_err != ST_OK) begin
         status = step_err;
      end else if (step_depth != '0 || step_quote) begin
         status = ST_UNCLOSED;
      end else begin
         status = ST_OK;
      end
      result = {5'b0, status, (status == ST_OK)};
   end

   always_comb begin
      if (emit) begin
         depth_in = '0;
         quote_in = 1'b0;
         esc_in   = 1'b0;
         err_in   = ST_OK;
      end else begin
         depth_in = step_depth;
         quote_in = step_quote;
         esc_in   = step_esc;
         err_in   = step_err;
      end
   end

   // two-entry output buffer: out register plus skid
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in  = skid_valid_ff;
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end
      if (emit) begin
         if (!out_valid_in) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff      <= '0;
         quote_ff      <= 1'b0;
         esc_ff        <= 1'b0;
         err_ff        <= ST_OK;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         depth_ff      <= depth_in;
         quote_ff      <= quote_in;
         esc_ff        <= esc_in;
         err_ff        <= err_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   `QBBC_ASSERT_NOW(a_depth_bound, 1'b1, depth_ff <= DEPTH_W'(MAX_DEPTH), "stack depth past limit")
   `QBBC_ASSERT_NOW(a_skid_order, skid_valid_ff, out_valid_ff, "skid entry without out entry")
   `QBBC_ASSERT_NEXT(a_clear_on_last, emit, depth_ff == '0 && !quote_ff && err_ff == ST_OK, "state not cleared after final beat")
   `QBBC_ASSERT_NEXT(a_err_latched, err_ff != ST_OK && !emit, $stable(err_ff), "latched error changed mid message")
   `QBBC_ASSERT_NOW(a_wf_status, rsp_tvalid, rsp_tdata[0] == (rsp_tdata[2:1] == ST_OK), "well_formed disagrees with status")

endmodule

[design/qbbc_cell.sv]
// One stack cell: holds a bracket kind and shifts with its neighbors.
module qbbc_cell
   import qbbc_pkg::*;
(
   input  logic          clock,
   input  stack_ctl_type ctl,
   input  logic          from_above,
   input  logic          from_below,
   output logic          kind
);

   logic kind_ff;
   logic kind_in;

   always_comb begin
      if (ctl.push) begin
         kind_in = from_above;
      end else if (ctl.pop) begin
         kind_in = from_below;
      end else begin
         kind_in = kind_ff;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   assign kind = kind_ff;

endmodule

[design/qbbc_stack.sv]
// Bracket stack: a row of shifting cells, top of stack in cell 0.
module qbbc_stack
   import qbbc_pkg::*;
(
   input  logic          clock,
   input  stack_ctl_type ctl,
   output logic          top_kind
);

   logic [MAX_DEPTH-1:0] kind_vec;
   logic [MAX_DEPTH-1:0] above_vec;
   logic [MAX_DEPTH-1:0] below_vec;

   always_comb begin
      above_vec = {kind_vec[MAX_DEPTH-2:0], ctl.kind};
      below_vec = {1'b0, kind_vec[MAX_DEPTH-1:1]};
   end

   for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
      qbbc_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .from_above (above_vec[i]),
         .from_below (below_vec[i]),
         .kind       (kind_vec[i])
      );
   end

   assign top_kind = kind_vec[0];

endmodule
